// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk, with or without the reset guard.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked at every clk edge with rst_n high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clk edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/lsmt_pkg.sv =====
// ---------------------------------------------------------------------------
// lsmt_pkg
// Shared constants for the LCD scanline mode timer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsmt_pkg;

  // Default timing
  localparam int LINE_CYCLES_DEF   = 456;
  localparam int VISIBLE_LINES_DEF = 144;
  localparam int LAST_LINE_DEF     = 153;

  // Mode phase lengths inside a line
  localparam int OAM_CYCLES      = 80;
  localparam int TRANSFER_CYCLES = 172;

  // Field widths
  localparam int CYC_W    = 9;
  localparam int LINE_W   = 8;
  localparam int MODE_W   = 2;
  localparam int ELAPSE_W = 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 8;
  localparam int IN_DW    = 8;
  localparam int OUT_DW   = 24;

  // LCD modes
  localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_DISPLAY_EN   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HBLANK_IRQ   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VBLANK_IRQ   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_OAM_IRQ      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_COMPARE_IRQ  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_COMPARE_LINE = 3'd5;

endpackage

// ===== rtl/core/lcd_scanline_mode_timer.sv =====
// ---------------------------------------------------------------------------
// lcd_scanline_mode_timer
// Scanline countdown, LCD mode, coincidence and interrupt requests.
// ---------------------------------------------------------------------------
// One word in gives one word out. Every input word is processed in the cycle
// it is accepted: the mode decode, line compare and countdown subtract sit
// between the timing state registers and a two-entry output buffer (output
// register plus skid) that registers each result. A word can be accepted
// every clock while in_tready is high; it only drops when both output entries
// are full. Configuration writes take effect at the clock edge of cfg_we.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lcd_scanline_mode_timer #(
  parameter int LINE_CYCLES   = lsmt_pkg::LINE_CYCLES_DEF,
  parameter int VISIBLE_LINES = lsmt_pkg::VISIBLE_LINES_DEF,
  parameter int LAST_LINE     = lsmt_pkg::LAST_LINE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words; tdata: elapsed_cycles[7:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [lsmt_pkg::IN_DW-1:0]  in_tdata,
  // result words; tdata: lcd_mode[1:0], current_line[9:2], coincidence[10],
  // stat_irq[11], vblank_irq[12], line_ready[13], ready_line[21:14], zero pad
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lsmt_pkg::OUT_DW-1:0] out_tdata,
  // configuration writes
  input  logic                        cfg_we,
  input  logic [lsmt_pkg::CFG_AW-1:0] cfg_waddr,
  input  logic [lsmt_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int CYC_W  = lsmt_pkg::CYC_W;
  localparam int LINE_W = lsmt_pkg::LINE_W;
  localparam int MODE_W = lsmt_pkg::MODE_W;

  localparam logic [CYC_W-1:0]  CYC_RELOAD = CYC_W'(LINE_CYCLES);
  localparam logic [CYC_W-1:0]  OAM_START  = CYC_W'(LINE_CYCLES - lsmt_pkg::OAM_CYCLES);
  localparam logic [CYC_W-1:0]  XFER_START =
    CYC_W'(LINE_CYCLES - lsmt_pkg::OAM_CYCLES - lsmt_pkg::TRANSFER_CYCLES);
  localparam logic [LINE_W-1:0] VIS_LINE   = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] LAST_LN    = LINE_W'(LAST_LINE);

  // configuration registers
  logic              display_en_r;
  logic              hblank_irq_en_r;
  logic              vblank_irq_en_r;
  logic              oam_irq_en_r;
  logic              compare_irq_en_r;
  logic [LINE_W-1:0] compare_line_r;

  // timing state
  logic [LINE_W-1:0] line_count_r, line_count_nxt;
  logic [CYC_W-1:0]  cycles_left_r, cycles_left_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              match_r, match_nxt;

  // output buffer
  logic                        out_valid_r, out_valid_nxt;
  logic [lsmt_pkg::OUT_DW-1:0] out_data_r, out_data_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  logic [lsmt_pkg::OUT_DW-1:0] skid_data_r;

  logic              in_acc;
  logic              out_acc;
  logic [lsmt_pkg::ELAPSE_W-1:0] elapsed;
  logic [MODE_W-1:0] dec_mode;
  logic              irq_en;
  logic              stat;
  logic              vblank;
  logic              ready;
  logic [LINE_W-1:0] ready_idx;
  logic [LINE_W-1:0] line_inc;
  logic [lsmt_pkg::OUT_DW-1:0] result;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;
  assign elapsed   = in_tdata[lsmt_pkg::ELAPSE_W-1:0];
  assign line_inc  = line_count_r + LINE_W'(1);

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_en_r     <= 1'b1;
      hblank_irq_en_r  <= 1'b0;
      vblank_irq_en_r  <= 1'b0;
      oam_irq_en_r     <= 1'b0;
      compare_irq_en_r <= 1'b0;
      compare_line_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_waddr)
        lsmt_pkg::REG_DISPLAY_EN:   display_en_r     <= cfg_wdata[0];
        lsmt_pkg::REG_HBLANK_IRQ:   hblank_irq_en_r  <= cfg_wdata[0];
        lsmt_pkg::REG_VBLANK_IRQ:   vblank_irq_en_r  <= cfg_wdata[0];
        lsmt_pkg::REG_OAM_IRQ:      oam_irq_en_r     <= cfg_wdata[0];
        lsmt_pkg::REG_COMPARE_IRQ:  compare_irq_en_r <= cfg_wdata[0];
        lsmt_pkg::REG_COMPARE_LINE: compare_line_r   <= cfg_wdata[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // mode decode from line and the countdown before it drops
  always_comb begin
    if (line_count_r >= VIS_LINE) begin
      dec_mode = lsmt_pkg::MODE_VBLANK;
      irq_en   = vblank_irq_en_r;
    end else if (cycles_left_r >= OAM_START) begin
      dec_mode = lsmt_pkg::MODE_OAM;
      irq_en   = oam_irq_en_r;
    end else if (cycles_left_r >= XFER_START) begin
      dec_mode = lsmt_pkg::MODE_TRANSFER;
      irq_en   = 1'b0;
    end else begin
      dec_mode = lsmt_pkg::MODE_HBLANK;
      irq_en   = hblank_irq_en_r;
    end
  end

  // step: next timing state and result flags
  always_comb begin
    line_count_nxt  = line_count_r;
    cycles_left_nxt = cycles_left_r;
    mode_nxt        = mode_r;
    match_nxt       = match_r;
    stat            = 1'b0;
    vblank          = 1'b0;
    ready           = 1'b0;
    ready_idx       = '0;
    if (!display_en_r) begin
      cycles_left_nxt = CYC_RELOAD;
      line_count_nxt  = '0;
      mode_nxt        = lsmt_pkg::MODE_VBLANK;
    end else begin
      mode_nxt  = dec_mode;
      match_nxt = (compare_line_r == line_count_r);
      stat      = (irq_en && (dec_mode != mode_r)) || (match_nxt && compare_irq_en_r);
      // countdown hits zero or below: reload, next line
      if (CYC_W'(elapsed) >= cycles_left_r) begin
        cycles_left_nxt = CYC_RELOAD;
        if (line_inc != '0 && line_inc <= VIS_LINE) begin
          ready     = 1'b1;
          ready_idx = line_inc - LINE_W'(1);
        end
        if (line_inc == VIS_LINE) begin
          vblank         = 1'b1;
          line_count_nxt = line_inc;
        end else if (line_inc > LAST_LN) begin
          line_count_nxt = '0;
        end else begin
          line_count_nxt = line_inc;
        end
      end else begin
        cycles_left_nxt = cycles_left_r - CYC_W'(elapsed);
      end
    end
  end

  assign result = {2'b00, ready_idx, ready, vblank, stat, match_nxt, line_count_nxt, mode_nxt};

  // timing state registers, updated per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r  <= '0;
      cycles_left_r <= CYC_RELOAD;
      mode_r        <= lsmt_pkg::MODE_HBLANK;
      match_r       <= 1'b0;
    end else if (in_acc) begin
      line_count_r  <= line_count_nxt;
      cycles_left_r <= cycles_left_nxt;
      mode_r        <= mode_nxt;
      match_r       <= match_nxt;
    end
  end

  // output register with skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = in_acc;
      end else begin
        out_valid_nxt = in_acc;
        out_data_nxt  = result;
      end
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      skid_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `ASSERT_CLK(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid full with output empty")
  `ASSERT_CLK(a_cycles_range, (cycles_left_r != '0) && (cycles_left_r <= CYC_RELOAD), "countdown out of range")
  `ASSERT_CLK(a_disabled_hold, (in_acc && !display_en_r) |=> (line_count_r == '0 && mode_r == lsmt_pkg::MODE_VBLANK), "disabled step did not reset timing")
  `ASSERT_CLK(a_ready_line, (in_acc && ready) |-> (ready_idx < VIS_LINE), "render line beyond visible area")
  `ASSERT_CLK(a_drain, (out_acc && !skid_valid_r && !in_acc) |=> !out_valid_r, "result repeated after drain")

endmodule
